// ===== rtl/sbsh_pkg.sv =====
// ----------------------------------------------------------------------------
// sbsh_pkg
// shared types and constants of the byte stream sha-256 hasher: the queued
// request item, the round constants and the initial hash value
// ----------------------------------------------------------------------------
package sbsh_pkg;

   typedef logic [31:0] word_type;
   typedef logic [7:0]  byte_type;

   typedef struct packed {
      logic     finish;
      byte_type data;
   } item_type;

   localparam byte_type PAD_MARK  = 8'h80;
   localparam int       LEN_START = 56;

   localparam word_type ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam word_type INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

endpackage

// ===== rtl/sbsh_front.sv =====
// ----------------------------------------------------------------------------
// sbsh_front
// request side: takes command beats into a short queue and hands them to the
// hashing core as append or finish items
// ----------------------------------------------------------------------------
module sbsh_front #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_command,
   input  logic [7:0]        req_data_byte,
   output logic              item_valid,
   input  logic              item_pop,
   output sbsh_pkg::item_type item
);
   import sbsh_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type             slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 push;
   logic                 pop;
   item_type             new_item;

   assign req_stall  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign item_valid = (count_ff != '0);
   assign item       = slot_ff[rd_ptr_ff];
   assign push       = req_valid && !req_stall;
   assign pop        = item_pop && item_valid;

   always_comb begin
      new_item.finish = req_command;
      new_item.data   = req_data_byte;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// ===== rtl/sbsh_core.sv =====
// ----------------------------------------------------------------------------
// sbsh_core
// hashing core: packs bytes into the schedule window, runs one compression
// round per cycle, generates the padding and shifts out the digest
// ----------------------------------------------------------------------------
module sbsh_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   output logic              item_pop,
   input  sbsh_pkg::item_type item,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [31:0]       rsp_digest_word,
   output logic [2:0]        rsp_word_index,
   output logic              rsp_last_word
);
   import sbsh_pkg::*;

   localparam logic [2:0] ST_LOAD  = 3'd0;
   localparam logic [2:0] ST_PAD   = 3'd1;
   localparam logic [2:0] ST_ROUND = 3'd2;
   localparam logic [2:0] ST_ADD   = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   localparam logic [5:0] FILL_LAST = 6'd63;
   localparam logic [5:0] ROUND_LAST = 6'd63;
   localparam logic [2:0] WORD_LAST = 3'd7;

   function automatic word_type rotr(input word_type x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic word_type bsig0(input word_type x);
      bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic word_type bsig1(input word_type x);
      bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic word_type ssig0(input word_type x);
      ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type ssig1(input word_type x);
      ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   logic [2:0]  state_ff, state_in;
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] bits_ff, bits_in;
   logic [5:0]  round_ff, round_in;
   logic [2:0]  index_ff, index_in;
   logic        fin_ff, fin_in;
   logic        pad_first_ff, pad_first_in;
   logic        zero_only_ff, zero_only_in;
   logic        last_ff, last_in;
   logic [23:0] acc_ff, acc_in;
   word_type    hash_ff [8];
   word_type    hash_in [8];
   word_type    work_ff [8];
   word_type    work_in [8];
   word_type    win_ff [16];
   word_type    win_in [16];

   logic        push_en;
   byte_type    push_byte;
   logic        in_len;
   word_type    w_next;
   word_type    t1;
   word_type    t2;
   word_type    ch;
   word_type    maj;

   assign rsp_valid       = (state_ff == ST_EMIT);
   assign rsp_digest_word = hash_ff[0];
   assign rsp_word_index  = index_ff;
   assign rsp_last_word   = (index_ff == WORD_LAST);

   // schedule and round datapath
   assign w_next = win_ff[0] + ssig0(win_ff[1]) + win_ff[9] + ssig1(win_ff[14]);
   assign ch     = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
   assign maj    = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
                 ^ (work_ff[1] & work_ff[2]);
   assign t1     = work_ff[7] + bsig1(work_ff[4]) + ch + ROUND_K[round_ff] + win_ff[0];
   assign t2     = bsig0(work_ff[0]) + maj;
   assign in_len = !pad_first_ff && !zero_only_ff && (fill_ff >= 6'(LEN_START));

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      bits_in      = bits_ff;
      round_in     = round_ff;
      index_in     = index_ff;
      fin_in       = fin_ff;
      pad_first_in = pad_first_ff;
      zero_only_in = zero_only_ff;
      last_in      = last_ff;
      acc_in       = acc_ff;
      hash_in      = hash_ff;
      work_in      = work_ff;
      win_in       = win_ff;
      push_en      = 1'b0;
      push_byte    = '0;
      item_pop     = 1'b0;

      unique case (state_ff)
         ST_LOAD: begin
            if (item_valid) begin
               item_pop = 1'b1;
               if (!item.finish) begin
                  push_en   = 1'b1;
                  push_byte = item.data;
                  bits_in   = bits_ff + 64'd8;
               end else begin
                  fin_in       = 1'b1;
                  pad_first_in = 1'b1;
                  state_in     = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            push_en      = 1'b1;
            pad_first_in = 1'b0;
            if (pad_first_ff) begin
               push_byte = PAD_MARK;
            end else if (in_len) begin
               push_byte = bits_ff[{~fill_ff[2:0], 3'b000} +: 8];
            end else begin
               push_byte = '0;
            end
            // mark placed at or past the start of the length field: zeros run into the next block
            if (fill_ff == FILL_LAST) begin
               zero_only_in = 1'b0;
            end else if (pad_first_ff && fill_ff >= 6'(LEN_START)) begin
               zero_only_in = 1'b1;
            end
            if (in_len && fill_ff == FILL_LAST) begin
               last_in = 1'b1;
            end
         end
         ST_ROUND: begin
            for (int i = 0; i < 15; i++) begin
               win_in[i] = win_ff[i+1];
            end
            win_in[15] = w_next;
            for (int i = 7; i > 0; i--) begin
               work_in[i] = work_ff[i-1];
            end
            work_in[4] = work_ff[3] + t1;
            work_in[0] = t1 + t2;
            round_in   = round_ff + 1'b1;
            if (round_ff == ROUND_LAST) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            for (int i = 0; i < 8; i++) begin
               hash_in[i] = hash_ff[i] + work_ff[i];
            end
            if (last_ff) begin
               state_in = ST_EMIT;
            end else if (fin_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_LOAD;
            end
         end
         ST_EMIT: begin
            if (!rsp_stall) begin
               for (int i = 0; i < 7; i++) begin
                  hash_in[i] = hash_ff[i+1];
               end
               hash_in[7] = hash_ff[0];
               index_in   = index_ff + 1'b1;
               if (index_ff == WORD_LAST) begin
                  hash_in  = INIT_HASH;
                  bits_in  = '0;
                  fin_in   = 1'b0;
                  last_in  = 1'b0;
                  state_in = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase

      // byte into the block; a full block starts the rounds
      if (push_en) begin
         fill_in = fill_ff + 1'b1;
         if (fill_ff[1:0] == 2'b11) begin
            for (int i = 0; i < 15; i++) begin
               win_in[i] = win_ff[i+1];
            end
            win_in[15] = {acc_ff, push_byte};
         end else begin
            acc_in = {acc_ff[15:0], push_byte};
         end
         if (fill_ff == FILL_LAST) begin
            work_in  = hash_ff;
            round_in = '0;
            state_in = ST_ROUND;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         fill_ff      <= '0;
         bits_ff      <= '0;
         round_ff     <= '0;
         index_ff     <= '0;
         fin_ff       <= 1'b0;
         pad_first_ff <= 1'b0;
         zero_only_ff <= 1'b0;
         last_ff      <= 1'b0;
         hash_ff      <= INIT_HASH;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         bits_ff      <= bits_in;
         round_ff     <= round_in;
         index_ff     <= index_in;
         fin_ff       <= fin_in;
         pad_first_ff <= pad_first_in;
         zero_only_ff <= zero_only_in;
         last_ff      <= last_in;
         hash_ff      <= hash_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      work_ff <= work_in;
      win_ff  <= win_in;
   end

endmodule

// ===== rtl/sha256_byte_stream_hasher_unit.sv =====
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_unit
// sha-256 of a byte stream, one message byte per request beat
// ----------------------------------------------------------------------------
// a request beat with req_command low appends req_data_byte to the message;
// a beat with req_command high closes the message. the digest then leaves
// on the response channel as eight beats, word 0 first, rsp_last_word set on
// word 7, and the unit starts over from the initial hash value.
// request beats go into a queue of QUEUE_DEPTH entries; req_stall rises only
// while that queue is full.
// while loading, the core takes one queued byte per cycle. every 64th byte
// starts a block compression, the rounds and then the chaining add, during
// which no byte is taken. a finish beat adds 9 to 72 padding bytes, one per
// cycle, and then one or two compressions run before the first digest beat.
// a stalled response holds its word and the core waits until it is taken;
// the queue keeps taking request beats until it is full.
// synchronous reset clears the queue, the bit count and the block fill and
// loads the initial hash value; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);
   import sbsh_pkg::*;

   logic     item_valid;
   logic     item_pop;
   item_type item;

   sbsh_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_command   (req_command),
      .req_data_byte (req_data_byte),
      .item_valid    (item_valid),
      .item_pop      (item_pop),
      .item          (item)
   );

   sbsh_core u_core (
      .clock           (clock),
      .reset           (reset),
      .item_valid      (item_valid),
      .item_pop        (item_pop),
      .item            (item),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word)
   );

   // last flag marks word 7 only
   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_word == (rsp_word_index == 3'd7)))
      else $error("last flag does not match word index");

   // digest words leave in order
   a_word_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last_word) |=>
         (rsp_valid && rsp_word_index == $past(rsp_word_index) + 3'd1))
      else $error("digest word out of order");

   // response closes after the final word
   a_digest_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last_word) |=> !rsp_valid)
      else $error("response still valid after final word");

   // a digest always opens at word 0
   a_digest_start: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> (rsp_word_index == 3'd0))
      else $error("digest does not start at word 0");

endmodule

// ===== test/tb_sha256_byte_stream_hasher_unit.sv =====
// ----------------------------------------------------------------------------
// tb_sha256_byte_stream_hasher_unit
// self-checking test of the byte stream sha-256 hasher
// ----------------------------------------------------------------------------
// message bytes and finish beats go in on the request channel. a software
// sha-256 running alongside computes the eight digest words of every finished
// message, and each response beat is compared field by field with the oldest
// word waiting. directed messages come first: the empty message, "abc" and
// the byte extremes. random messages follow, every other one sized at a
// padding boundary (55, 56, 64, 63 bytes) as far as the item budget allows,
// under three idling patterns of sender and receiver.
// ----------------------------------------------------------------------------
module tb_sha256_byte_stream_hasher_unit;

   localparam logic CMD_APPEND = 1'b0;
   localparam logic CMD_FINISH = 1'b1;

   localparam int TAIL_CYCLES = 400;

   localparam int BOUNDARY_LENS [4] = '{55, 56, 64, 63};

   localparam logic [31:0] SHA_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] SHA_H0 [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   typedef struct {
      logic [31:0] word;
      logic [2:0]  index;
      logic        is_last;
   } digest_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_command = CMD_APPEND;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   logic [31:0] hash_state [8];
   logic [7:0]  block_buf [64];
   int unsigned block_count;
   logic [63:0] bit_count;

   digest_beat_type expected_words [$];

   int error_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit boundary_turn = 1'b0;
   int boundary_pick = 0;

   sha256_byte_stream_hasher_unit u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word)
   );

   always #5 clock = ~clock;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic hash_restart();
      for (int i = 0; i < 8; i++) hash_state[i] = SHA_H0[i];
      block_count = 0;
      bit_count   = 64'd0;
   endtask

   task automatic hash_compress();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] s0, s1, t1, t2;
      for (int t = 0; t < 16; t++) begin
         w[t] = {block_buf[4*t], block_buf[4*t+1], block_buf[4*t+2], block_buf[4*t+3]};
      end
      for (int t = 16; t < 64; t++) begin
         s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
         s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
         w[t] = w[t-16] + s0 + w[t-7] + s1;
      end
      for (int i = 0; i < 8; i++) v[i] = hash_state[i];
      for (int t = 0; t < 64; t++) begin
         t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[t] + w[t];
         t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6];
         v[6] = v[5];
         v[5] = v[4];
         v[4] = v[3] + t1;
         v[3] = v[2];
         v[2] = v[1];
         v[1] = v[0];
         v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_state[i] = hash_state[i] + v[i];
   endtask

   task automatic hash_push(input logic [7:0] b);
      block_buf[block_count] = b;
      block_count = (block_count + 1) % 64;
      if (block_count == 0) hash_compress();
   endtask

   task automatic digest_predict(input logic cmd, input logic [7:0] data);
      logic [63:0] msg_len;
      digest_beat_type beat;
      if (cmd == CMD_APPEND) begin
         hash_push(data);
         bit_count = bit_count + 64'd8;
      end else begin
         msg_len = bit_count;
         hash_push(8'h80);
         while (block_count != 56) hash_push(8'h00);
         for (int i = 0; i < 8; i++) hash_push(msg_len[63 - 8*i -: 8]);
         for (int i = 0; i < 8; i++) begin
            beat.word    = hash_state[i];
            beat.index   = 3'(i);
            beat.is_last = (i == 7);
            expected_words.push_back(beat);
         end
         hash_restart();
      end
   endtask

   initial hash_restart();

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) digest_predict(req_command, req_data_byte);
   end

   always @(posedge clock) begin
      digest_beat_type exp_beat;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            $error("unexpected digest beat: word %h index %0d", rsp_digest_word,
                   rsp_word_index);
            error_count++;
         end else begin
            exp_beat = expected_words.pop_front();
            if (rsp_digest_word !== exp_beat.word) begin
               $error("rsp_digest_word: expected %h, actual %h", exp_beat.word,
                      rsp_digest_word);
               error_count++;
            end
            if (rsp_word_index !== exp_beat.index) begin
               $error("rsp_word_index: expected %0d, actual %0d", exp_beat.index,
                      rsp_word_index);
               error_count++;
            end
            if (rsp_last_word !== exp_beat.is_last) begin
               $error("rsp_last_word: expected %0b, actual %0b", exp_beat.is_last,
                      rsp_last_word);
               error_count++;
            end
         end
      end
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   task automatic send_beat(input logic cmd, input logic [7:0] data);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_command   <= cmd;
      req_data_byte <= data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic test_empty_message();
      send_beat(CMD_FINISH, 8'h00);
   endtask

   task automatic test_abc_message();
      send_beat(CMD_APPEND, 8'h61);
      send_beat(CMD_APPEND, 8'h62);
      send_beat(CMD_APPEND, 8'h63);
      send_beat(CMD_FINISH, 8'hff);
   endtask

   task automatic test_byte_extremes();
      send_beat(CMD_APPEND, 8'h00);
      send_beat(CMD_APPEND, 8'hff);
      send_beat(CMD_APPEND, 8'h80);
      send_beat(CMD_APPEND, 8'h7f);
      send_beat(CMD_APPEND, 8'h01);
      send_beat(CMD_FINISH, 8'h5a);
   endtask

   task automatic test_random_messages(input int item_budget);
      int sent;
      int msg_bytes;
      sent = 0;
      while (sent < item_budget) begin
         if (boundary_turn) begin
            msg_bytes = BOUNDARY_LENS[boundary_pick % 4];
            boundary_pick++;
         end else begin
            msg_bytes = $urandom_range(0, 15);
         end
         boundary_turn = !boundary_turn;
         if (msg_bytes > item_budget - sent - 1) msg_bytes = item_budget - sent - 1;
         for (int n = 0; n < msg_bytes; n++) send_beat(CMD_APPEND, 8'($urandom_range(0, 255)));
         send_beat(CMD_FINISH, 8'($urandom_range(0, 255)));
         sent += msg_bytes + 1;
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_empty_message();
      test_abc_message();
      test_byte_extremes();

      send_idle_pct = 8;
      recv_idle_pct = 62;
      test_random_messages(70);

      send_idle_pct = 62;
      recv_idle_pct = 8;
      test_random_messages(70);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_messages(70);

      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
